// ----- hw/rtl/bmfp_pkg.sv -----
// Package for the battery monitor frame parser.
// Holds the front-to-back event type, result kinds, frame layout, queue depth
// and the tag, length and kind tables. It depends on nothing else.
package bmfp_pkg;

    // Result kinds
    localparam logic [3:0] KIND_CELL      = 4'd0;
    localparam logic [3:0] KIND_TEMP_FET  = 4'd1;
    localparam logic [3:0] KIND_TEMP_B1   = 4'd2;
    localparam logic [3:0] KIND_TEMP_B2   = 4'd3;
    localparam logic [3:0] KIND_PACK_MV   = 4'd4;
    localparam logic [3:0] KIND_CURRENT   = 4'd5;
    localparam logic [3:0] KIND_SOC       = 4'd6;
    localparam logic [3:0] KIND_CYCLES    = 4'd7;
    localparam logic [3:0] KIND_CAPACITY  = 4'd8;
    localparam logic [3:0] KIND_WARNINGS  = 4'd9;
    localparam logic [3:0] KIND_STATUS    = 4'd10;
    localparam logic [3:0] KIND_TAG_ERR   = 4'd11;
    localparam logic [3:0] KIND_COUNT_WRN = 4'd12;
    localparam logic [3:0] KIND_SKIP      = 4'd15;

    // Frame layout
    localparam logic [3:0] HDR_LEN     = 4'd11;
    localparam logic [3:0] NUM_FIELDS  = 4'd13;
    localparam logic [3:0] LAST_FIELD  = 4'd12;

    // Event queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // One parsed field, not yet decoded
    typedef struct packed {
        logic [3:0]  kind;
        logic [4:0]  idx;
        logic [31:0] raw;
        logic        last;
    } event_t;

    // Expected tag of each field slot
    function automatic logic [7:0] fld_tag(input logic [3:0] f);
        logic [7:0] t;
        unique case (f)
            4'd0:    t = 8'h79;
            4'd1:    t = 8'h80;
            4'd2:    t = 8'h81;
            4'd3:    t = 8'h82;
            4'd4:    t = 8'h83;
            4'd5:    t = 8'h84;
            4'd6:    t = 8'h85;
            4'd7:    t = 8'h86;
            4'd8:    t = 8'h87;
            4'd9:    t = 8'h89;
            4'd10:   t = 8'h8a;
            4'd11:   t = 8'h8b;
            4'd12:   t = 8'h8c;
            default: t = 8'h00;
        endcase
        return t;
    endfunction

    // Data length in bytes of each field slot
    function automatic logic [3:0] fld_len(input logic [3:0] f);
        logic [3:0] n;
        unique case (f)
            4'd0, 4'd6, 4'd7: n = 4'd1;
            4'd9:             n = 4'd4;
            default:          n = 4'd2;
        endcase
        return n;
    endfunction

    // Result kind of each field slot
    function automatic logic [3:0] fld_kind(input logic [3:0] f);
        logic [3:0] k;
        unique case (f)
            4'd0:    k = KIND_CELL;
            4'd1:    k = KIND_TEMP_FET;
            4'd2:    k = KIND_TEMP_B1;
            4'd3:    k = KIND_TEMP_B2;
            4'd4:    k = KIND_PACK_MV;
            4'd5:    k = KIND_CURRENT;
            4'd6:    k = KIND_SOC;
            4'd8:    k = KIND_CYCLES;
            4'd9:    k = KIND_CAPACITY;
            4'd11:   k = KIND_WARNINGS;
            4'd12:   k = KIND_STATUS;
            default: k = KIND_SKIP;
        endcase
        return k;
    endfunction

endpackage

// ----- hw/rtl/bmfp_front.sv -----
// Front end of the frame parser: walks the frame byte by byte, checks tags,
// gathers big-endian fields and pushes a raw event for each non-skipped field,
// each tag error and each cell count warning. Depends on bmfp_pkg.
module bmfp_front
    import bmfp_pkg::*;
#(
    parameter int CELLS = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       byte_valid,
    input  logic [7:0] byte_data,
    input  logic       frame_start,
    output logic       ev_valid,
    output event_t     ev
);

    // Phase codes; field slots use 2..27 (tag/data pairs)
    localparam logic [4:0] PH_IDLE   = 5'd0;
    localparam logic [4:0] PH_HEADER = 5'd1;
    localparam logic [4:0] PH_FIRST  = 5'd2;
    localparam logic [4:0] PH_PACK   = 5'd4;
    localparam logic [4:0] PH_LASTF  = 5'd27;
    localparam logic [4:0] PH_CELLS  = 5'd28;

    logic [4:0]  phase_reg, phase_next;
    logic [3:0]  pos_reg, pos_next;
    logic [6:0]  remain_reg, remain_next;
    logic [6:0]  ccount_reg, ccount_next;
    logic [31:0] gather_reg, gather_next;

    logic [4:0]  rel;
    logic [3:0]  f;
    logic [3:0]  pos_inc;
    logic [31:0] gather_shift;
    logic [15:0] div_prod;
    logic [6:0]  cnt;
    logic [3:0]  fkind;

    assign rel          = phase_reg - PH_FIRST;
    assign f            = rel[4:1];
    assign pos_inc      = pos_reg + 4'd1;
    assign gather_shift = {gather_reg[23:0], byte_data};
    // byte / 3 as a reciprocal multiply, exact for 8-bit input
    assign div_prod     = {8'd0, byte_data} * 16'd171;
    assign cnt          = div_prod[15:9];
    assign fkind        = fld_kind(f);

    // Next-state and event logic
    always_comb begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        remain_next = remain_reg;
        ccount_next = ccount_reg;
        gather_next = gather_reg;
        ev_valid    = 1'b0;
        ev          = '0;
        if (byte_valid) begin
            priority if (frame_start) begin
                phase_next  = PH_HEADER;
                pos_next    = 4'd1;
                remain_next = '0;
                ccount_next = '0;
                gather_next = '0;
            end else if (phase_reg == PH_IDLE) begin
                phase_next = PH_IDLE;
            end else if (phase_reg == PH_HEADER) begin
                pos_next = pos_inc;
                if (pos_inc >= HDR_LEN) begin
                    phase_next = PH_FIRST;
                    pos_next   = '0;
                end
            end else if (phase_reg == PH_CELLS) begin
                priority if (pos_reg == 4'd0) begin
                    pos_next    = 4'd1;
                    gather_next = '0;
                end else if (pos_reg == 4'd1) begin
                    gather_next = gather_shift;
                    pos_next    = 4'd2;
                end else begin
                    gather_next = gather_shift;
                    pos_next    = '0;
                    if (ccount_reg < 7'(CELLS)) begin
                        ev_valid = 1'b1;
                        ev.kind  = KIND_CELL;
                        ev.idx   = ccount_reg[4:0];
                        ev.raw   = {16'd0, gather_shift[15:0]};
                        ev.last  = 1'b0;
                    end
                    ccount_next = ccount_reg + 7'd1;
                    remain_next = remain_reg - 7'd1;
                    if (remain_reg == 7'd1) begin
                        phase_next = PH_PACK;
                    end
                end
            end else if (phase_reg < PH_FIRST || phase_reg > PH_LASTF) begin
                phase_next = PH_IDLE;
            end else if (!rel[0]) begin
                // Tag byte
                if (byte_data != fld_tag(f)) begin
                    ev_valid   = 1'b1;
                    ev.kind    = KIND_TAG_ERR;
                    ev.raw     = {24'd0, fld_tag(f)};
                    ev.last    = 1'b1;
                    phase_next = PH_IDLE;
                end else begin
                    phase_next  = phase_reg + 5'd1;
                    pos_next    = '0;
                    gather_next = '0;
                end
            end else if (f == 4'd0) begin
                // Cell count byte
                remain_next = cnt;
                ccount_next = '0;
                pos_next    = '0;
                phase_next  = (cnt != 7'd0) ? PH_CELLS : PH_PACK;
                if (cnt != 7'(CELLS)) begin
                    ev_valid = 1'b1;
                    ev.kind  = KIND_COUNT_WRN;
                    ev.raw   = {25'd0, cnt};
                end
            end else begin
                // Field data byte
                gather_next = gather_shift;
                pos_next    = pos_inc;
                if (pos_inc >= fld_len(f)) begin
                    pos_next   = '0;
                    phase_next = (f == LAST_FIELD) ? PH_IDLE : phase_reg + 5'd1;
                    if (fkind != KIND_SKIP) begin
                        ev_valid = 1'b1;
                        ev.kind  = fkind;
                        ev.raw   = gather_shift;
                        ev.last  = (f == LAST_FIELD);
                    end
                end
            end
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            pos_reg    <= '0;
            remain_reg <= '0;
            ccount_reg <= '0;
            gather_reg <= '0;
        end else begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            remain_reg <= remain_next;
            ccount_reg <= ccount_next;
            gather_reg <= gather_next;
        end
    end

endmodule

// ----- hw/rtl/bmfp_queue.sv -----
// Short event queue between the parser front and the decode back end.
// Depends on bmfp_pkg for the event type and depth.
module bmfp_queue
    import bmfp_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  event_t push_data,
    output logic   not_full,
    input  logic   pop,
    output logic   head_valid,
    output event_t head
);

    event_t              mem [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]     count_reg, count_next;
    logic                do_push, do_pop;

    assign not_full   = (count_reg < (QPTR_W+1)'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];
    assign do_push    = push && not_full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        count_next = count_reg;
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + (QPTR_W+1)'(1);
            2'b01:   count_next = count_reg - (QPTR_W+1)'(1);
            default: count_next = count_reg;
        endcase
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

// ----- hw/rtl/bmfp_back.sv -----
// Back end of the frame parser: decodes raw field events (temperatures,
// scaled voltage and current) into a registered result stage.
// Depends on bmfp_pkg.
module bmfp_back
    import bmfp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         head_valid,
    input  event_t       head,
    output logic         pop,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [3:0]   out_kind,
    output logic [4:0]   out_idx,
    output logic [32:0]  out_value,
    output logic         out_last
);

    logic        valid_reg;
    logic [3:0]  kind_reg;
    logic [4:0]  idx_reg;
    logic [32:0] value_reg, value_next;
    logic        last_reg;
    logic        load;

    logic [7:0]  temp8;
    logic [32:0] times10;

    assign load = !valid_reg || out_ready;
    assign pop  = load && head_valid;

    // Temperature fold and x10 scaling
    assign temp8   = (head.raw > 32'd100) ? (8'd100 - head.raw[7:0]) : head.raw[7:0];
    assign times10 = {1'b0, head.raw[28:0], 3'b000} + {1'b0, head.raw[30:0], 1'b0};

    always_comb begin
        unique case (head.kind)
            KIND_TEMP_FET, KIND_TEMP_B1, KIND_TEMP_B2:
                value_next = {{25{temp8[7]}}, temp8};
            KIND_PACK_MV:
                value_next = times10;
            KIND_CURRENT:
                value_next = head.raw[15] ? (33'd0 - times10) : times10;
            default:
                value_next = {1'b0, head.raw};
        endcase
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= head_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            kind_reg  <= head.kind;
            idx_reg   <= head.idx;
            value_reg <= value_next;
            last_reg  <= head.last;
        end
    end

    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_idx   = idx_reg;
    assign out_value = value_reg;
    assign out_last  = last_reg;

endmodule

// ----- hw/rtl/battery_monitor_frame_parser.sv -----
// Battery monitor status frame parser, top level.
// Throughput: one byte per cycle while the event queue is not full; the front takes each byte as it is accepted.
// Path: the byte that finishes a field makes an event in the front, which is written
// into the 4-entry event queue, then decoded into the output register.
// Reset: synchronous, active-low aresetn returns the parser to idle and empties
// the queue and output stage; no memory clearing pass is needed.
module battery_monitor_frame_parser
    import bmfp_pkg::*;
#(
    parameter int CELLS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_in
    input  logic        s_tuser,   // [0] frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [4:0] cell_index, [37:5] value, [39:38] zero
    output logic [3:0]  m_tuser,   // [3:0] item_kind
    output logic        m_tlast
);

    logic   ev_valid;
    event_t ev;
    logic   q_not_full;
    logic   q_pop;
    logic   q_head_valid;
    event_t q_head;
    logic   [4:0]  out_idx;
    logic   [32:0] out_value;

    assign s_tready = q_not_full;

    bmfp_front #(
        .CELLS(CELLS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_valid  (s_tvalid && s_tready),
        .byte_data   (s_tdata),
        .frame_start (s_tuser),
        .ev_valid    (ev_valid),
        .ev          (ev)
    );

    bmfp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (ev_valid),
        .push_data  (ev),
        .not_full   (q_not_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head       (q_head)
    );

    bmfp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_head_valid),
        .head       (q_head),
        .pop        (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_kind   (m_tuser),
        .out_idx    (out_idx),
        .out_value  (out_value),
        .out_last   (m_tlast)
    );

    assign m_tdata = {2'b00, out_value, out_idx};

endmodule

// ----- bench/tb_battery_monitor_frame_parser.sv -----
// Self-checking bench for battery_monitor_frame_parser: drives status frames
// byte by byte and checks every decoded field against a behavioral predictor.
// Depends on bmfp_pkg (result kind codes) and the parser RTL.
module tb_battery_monitor_frame_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import bmfp_pkg::*;

    localparam int CELLS          = 16;
    localparam int HEADER_BYTES   = 11;
    localparam int LAST_SLOT      = 12;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int STALL_LIMIT    = 2000;
    localparam int RESULT_LATENCY = 4;
    localparam int MAX_REPORTS    = 100;
    localparam int RANDOM_BYTES   = 600;

    // Parser phases: header, then tag/data pairs per slot, plus the cell triplets
    localparam logic [4:0] PHASE_IDLE       = 5'd0;
    localparam logic [4:0] PHASE_HEADER     = 5'd1;
    localparam logic [4:0] PHASE_FIRST_TAG  = 5'd2;
    localparam logic [4:0] PHASE_CELLS_DONE = 5'd4;
    localparam logic [4:0] PHASE_CELLS      = 5'd28;

    typedef struct packed {
        logic [3:0]  kind;
        logic [4:0]  idx;
        logic [32:0] value;
        logic        last;
    } field_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] byte_in
    logic        s_tuser;   // [0] frame_start
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // [4:0] cell_index, [37:5] value, [39:38] zero
    logic [3:0]  m_tuser;   // [3:0] item_kind
    logic        m_tlast;

    battery_monitor_frame_parser #(.CELLS(CELLS)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Predicted parser state
    logic [4:0]  phase      = PHASE_IDLE;
    logic [3:0]  pos        = '0;
    logic [6:0]  cells_left = '0;
    logic [6:0]  cell_no    = '0;
    logic [31:0] word       = '0;

    field_result_t expected_fields[$];
    logic [7:0]    frame_q[$];
    int            tag_slots[$];

    int error_count    = 0;
    int useful_bytes   = 0;
    int quiet_cycles   = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit rx_hold_req    = 1'b0;

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // Field layout of a status frame
    function automatic logic [7:0] tag_for(input int f);
        return (f == 0) ? 8'h79 : (f <= 8) ? 8'(8'h7f + f) : 8'(8'h80 + f);
    endfunction

    function automatic int len_for(input int f);
        case (f)
            0, 6, 7: return 1;
            9:       return 4;
            default: return 2;
        endcase
    endfunction

    function automatic logic [3:0] kind_for(input int f);
        case (f)
            0:       return KIND_CELL;
            1:       return KIND_TEMP_FET;
            2:       return KIND_TEMP_B1;
            3:       return KIND_TEMP_B2;
            4:       return KIND_PACK_MV;
            5:       return KIND_CURRENT;
            6:       return KIND_SOC;
            8:       return KIND_CYCLES;
            9:       return KIND_CAPACITY;
            11:      return KIND_WARNINGS;
            12:      return KIND_STATUS;
            default: return KIND_SKIP;
        endcase
    endfunction

    // Scale and sign a gathered raw field
    function automatic logic [32:0] decode_value(input logic [3:0] kind, input logic [31:0] raw);
        logic [31:0] diff;
        logic [7:0]  t;
        longint      v;
        case (kind)
            KIND_TEMP_FET, KIND_TEMP_B1, KIND_TEMP_B2: begin
                diff = (raw > 32'd100) ? 32'd100 - raw : raw;
                t = diff[7:0];
                v = {{56{t[7]}}, t};
            end
            KIND_PACK_MV: begin
                v = {32'd0, raw};
                v = v * 10;
            end
            KIND_CURRENT: begin
                v = {32'd0, raw};
                v = v * 10;
                if (raw[15]) v = -v;
            end
            default: v = {32'd0, raw};
        endcase
        return v[32:0];
    endfunction

    function automatic void queue_result(input logic [3:0] kind, input logic [4:0] idx,
                                         input logic [32:0] value, input logic last);
        field_result_t r;
        r.kind  = kind;
        r.idx   = idx;
        r.value = value;
        r.last  = last;
        expected_fields.push_back(r);
    endfunction

    // Advance the predicted parser by one accepted byte
    function automatic void predict_byte(input logic [7:0] b, input logic start);
        int f;
        int cnt;
        logic [3:0] k;
        if (start) begin
            phase = PHASE_HEADER;
            pos = 4'd1;
            cells_left = '0;
            cell_no = '0;
            word = '0;
            return;
        end
        if (phase == PHASE_IDLE) return;
        if (phase == PHASE_HEADER) begin
            pos = pos + 4'd1;
            if (pos >= HEADER_BYTES) begin
                phase = PHASE_FIRST_TAG;
                pos = '0;
            end
            return;
        end
        // cell triplet: id byte, then big-endian millivolts
        if (phase == PHASE_CELLS) begin
            if (pos == 4'd0) begin
                pos = 4'd1;
                word = '0;
                return;
            end
            word = {word[23:0], b};
            if (pos == 4'd1) begin
                pos = 4'd2;
                return;
            end
            pos = '0;
            if (cell_no < CELLS) queue_result(KIND_CELL, cell_no[4:0], {17'd0, word[15:0]}, 1'b0);
            cell_no = cell_no + 7'd1;
            cells_left = cells_left - 7'd1;
            if (cells_left == 7'd0) phase = PHASE_CELLS_DONE;
            return;
        end
        f = (int'(phase) - 2) / 2;
        // tag byte
        if (!phase[0]) begin
            if (b != tag_for(f)) begin
                queue_result(KIND_TAG_ERR, 5'd0, {25'd0, tag_for(f)}, 1'b1);
                phase = PHASE_IDLE;
                return;
            end
            phase = phase + 5'd1;
            pos = '0;
            word = '0;
            return;
        end
        // cell count byte
        if (f == 0) begin
            cnt = b / 3;
            cells_left = 7'(cnt);
            cell_no = '0;
            pos = '0;
            phase = (cnt != 0) ? PHASE_CELLS : PHASE_CELLS_DONE;
            if (cnt != CELLS) queue_result(KIND_COUNT_WRN, 5'd0, 33'(cnt), 1'b0);
            return;
        end
        word = {word[23:0], b};
        pos = pos + 4'd1;
        if (pos < len_for(f)) return;
        pos = '0;
        k = kind_for(f);
        phase = (f == LAST_SLOT) ? PHASE_IDLE : 5'(2 + 2 * (f + 1));
        if (k != KIND_SKIP) queue_result(k, 5'd0, decode_value(k, word), f == LAST_SLOT);
    endfunction

    function automatic void compare_field(input string name, input logic [32:0] want,
                                          input logic [32:0] got);
        if (got !== want) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, $signed(want), $signed(got));
        end
    endfunction

    // Input transfers feed the predictor; output transfers are checked in order
    always @(posedge aclk) begin : result_check
        field_result_t want;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            if (aresetn && s_tvalid && s_tready) begin
                if (s_tuser || phase != PHASE_IDLE) useful_bytes++;
                predict_byte(s_tdata, s_tuser);
            end
            if (aresetn && m_tvalid && m_tready) begin
                if (expected_fields.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: unexpected result, expected none, actual kind %0d value %0d",
                                 $time, m_tuser, $signed(m_tdata[37:5]));
                end else begin
                    want = expected_fields.pop_front();
                    compare_field("item_kind", {29'd0, want.kind}, {29'd0, m_tuser});
                    compare_field("cell_index", {28'd0, want.idx}, {28'd0, m_tdata[4:0]});
                    compare_field("value", want.value, m_tdata[37:5]);
                    compare_field("last", {32'd0, want.last}, {32'd0, m_tlast});
                end
            end
        end
    end

    // Result side: random stalls, or one long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge aclk);
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // One byte transfer; entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic start);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= start;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (expected_fields.size() != 0) @(negedge aclk);
        repeat (RESULT_LATENCY) @(negedge aclk);
    endtask

    function automatic logic [31:0] pick_field_value(input int nbytes, input bit use_fill,
                                                     input logic [31:0] fill);
        logic [31:0] v;
        if (use_fill) v = fill;
        else begin
            case ($urandom_range(7))
                0:       v = '0;
                1:       v = '1;
                2:       v = 32'd100;
                3:       v = 32'd101;
                4:       v = 32'h8000;
                5:       v = 32'd228;
                default: v = $urandom;
            endcase
        end
        return v & (32'hffff_ffff >> (32 - 8 * nbytes));
    endfunction

    // Well-formed frame into frame_q; tag_slots records where each tag sits
    task automatic build_frame(input logic [7:0] count_byte, input bit use_fill,
                               input logic [31:0] fill);
        logic [31:0] v;
        frame_q.delete();
        tag_slots.delete();
        repeat (HEADER_BYTES) frame_q.push_back(8'($urandom));
        tag_slots.push_back(frame_q.size());
        frame_q.push_back(tag_for(0));
        frame_q.push_back(count_byte);
        for (int c = 0; c < count_byte / 3; c++) begin
            v = pick_field_value(2, use_fill, fill);
            frame_q.push_back(8'(c + 1));
            frame_q.push_back(v[15:8]);
            frame_q.push_back(v[7:0]);
        end
        for (int f = 1; f <= LAST_SLOT; f++) begin
            tag_slots.push_back(frame_q.size());
            frame_q.push_back(tag_for(f));
            v = pick_field_value(len_for(f), use_fill, fill);
            for (int n = len_for(f) - 1; n >= 0; n--) frame_q.push_back(v[8*n +: 8]);
        end
    endtask

    // Send frame_q, optionally stopping early or corrupting one tag
    task automatic send_frame(input int cut_at, input int bad_slot);
        int bad_pos;
        bad_pos = (bad_slot >= 0) ? tag_slots[bad_slot] : -1;
        for (int i = 0; i < frame_q.size(); i++) begin
            if (i == cut_at) break;
            send_byte((i == bad_pos) ? frame_q[i] ^ 8'($urandom_range(255, 1)) : frame_q[i],
                      i == 0);
        end
    endtask

    // Bytes before any frame start are dropped
    task automatic test_idle_bytes();
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h79, 1'b0);
        send_byte(8'($urandom), 1'b0);
    endtask

    // Count below one triplet, all fields zero
    task automatic test_empty_cell_block();
        build_frame(8'd2, 1'b1, '0);
        send_frame(-1, -1);
    endtask

    // More cells than the pack holds, all fields at their maximum
    task automatic test_excess_cells();
        build_frame(8'd56, 1'b1, '1);
        send_frame(-1, -1);
    endtask

    // Wrong tag on the cell block, a skipped field and the status field
    task automatic test_wrong_tag();
        build_frame(8'd2, 1'b0, '0);
        send_frame(-1, 0);
        send_frame(-1, 7);
        send_frame(-1, LAST_SLOT);
    endtask

    // New frame start inside the header, the cell block and the fields
    task automatic test_restart();
        build_frame(8'd9, 1'b0, '0);
        send_frame(5, -1);
        send_frame(20, -1);
        send_frame(40, -1);
        send_frame(-1, -1);
        wait_results_drained();
    endtask

    // Receiver holds off long enough for the parser to back up its input
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        build_frame(8'd48, 1'b0, '0);
        rx_hold_req = 1'b1;
        send_frame(-1, -1);
        wait_results_drained();
    endtask

    // Mostly good frames with random content, some broken ones and stray bytes
    task automatic test_random_frames(input int idle_pct, input int stall_pct, input int n_bytes);
        int goal;
        int r;
        logic [7:0] count_byte;
        goal = useful_bytes + n_bytes;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        while (useful_bytes < goal) begin
            r = $urandom_range(99);
            if (r < 35) count_byte = 8'(48 + $urandom_range(2));
            else if (r < 75) count_byte = 8'($urandom_range(20));
            else if (r < 95) count_byte = 8'($urandom_range(100));
            else count_byte = 8'($urandom_range(255, 101));
            build_frame(count_byte, 1'b0, '0);
            r = $urandom_range(99);
            if (r < 75) send_frame(-1, -1);
            else if (r < 87) send_frame(-1, $urandom_range(LAST_SLOT));
            else if (r < 97) send_frame($urandom_range(frame_q.size() - 1, 1), -1);
            else repeat ($urandom_range(6, 1)) send_byte(8'($urandom), 1'b0);
        end
        wait_results_drained();
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 30;
        recv_stall_pct = 49;
        test_idle_bytes();
        test_empty_cell_block();
        test_excess_cells();
        test_wrong_tag();
        test_restart();
        test_backpressure();
        test_random_frames(30, 49, RANDOM_BYTES / 3);
        test_random_frames(49, 30, RANDOM_BYTES / 3);
        test_random_frames(0, 0, RANDOM_BYTES - 2 * (RANDOM_BYTES / 3));

        repeat (2 * RESULT_LATENCY) @(negedge aclk);
        if (error_count == 0 && expected_fields.size() == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/bmfp_pkg.sv
hw/rtl/bmfp_front.sv
hw/rtl/bmfp_queue.sv
hw/rtl/bmfp_back.sv
hw/rtl/battery_monitor_frame_parser.sv
bench/tb_battery_monitor_frame_parser.sv
